// ===== rtl/bell_key_maximum_picker_assert.svh =====
// assertion macros for the key maximum picker
// used by bkmp_core, no other dependencies
`ifndef BELL_KEY_MAXIMUM_PICKER_ASSERT_SVH
`define BELL_KEY_MAXIMUM_PICKER_ASSERT_SVH

`ifndef SYNTHESIS
`define BKMP_ASSERT_NOW(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define BKMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BKMP_ASSERT_NOW(label, clk, rst_n, prop)
`define BKMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bkmp_pkg.sv =====
// shared types and constants of the key maximum picker
// no dependencies
package bkmp_pkg;

    localparam int KEY_MAX     = 16;
    localparam int KEY_CNT_W   = $clog2(KEY_MAX + 1);
    localparam int POS_W       = 16;
    localparam int VAL_W       = 32;
    localparam int PHASE_W     = 2;
    localparam int FRAME_LEN_W = 16;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = FRAME_LEN_W'(1024);

    typedef struct packed {
        logic signed [VAL_W-1:0] sample;
        logic                    clear;
    } t_in;

    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic [POS_W-1:0]        sample_position;
        logic                    key_found;
        logic                    key_dropped;
        logic [POS_W-1:0]        key_position;
        logic signed [VAL_W-1:0] key_value;
        logic [KEY_CNT_W-1:0]    key_total;
        logic [POS_W-1:0]        best_position;
        logic signed [VAL_W-1:0] best_value;
    } t_out;

endpackage

// ===== rtl/bkmp_core.sv =====
// bell tracking state machine and per-sample result logic
// depends on bkmp_pkg and bell_key_maximum_picker_assert.svh
`include "bell_key_maximum_picker_assert.svh"

module bkmp_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  bkmp_pkg::t_in                         i_in,
    input  logic [bkmp_pkg::FRAME_LEN_W-1:0]      i_frame_length,
    output bkmp_pkg::t_out                        o_result
);

    typedef enum logic [bkmp_pkg::PHASE_W-1:0] {
        PH_SEARCH,
        PH_BELL,
        PH_END
    } t_phase;

    t_phase                                r_phase, n_phase, c_phase;
    logic [bkmp_pkg::POS_W-1:0]            r_next_position, n_next_position, c_pos;
    logic signed [bkmp_pkg::VAL_W-1:0]     r_prev, c_prev;
    logic signed [bkmp_pkg::VAL_W-1:0]     r_bell_val, n_bell_val, c_bell_val;
    logic [bkmp_pkg::POS_W-1:0]            r_bell_pos, n_bell_pos, c_bell_pos;
    logic [bkmp_pkg::KEY_CNT_W-1:0]        r_key_count, n_key_count, c_key_count;
    logic signed [bkmp_pkg::VAL_W-1:0]     r_glob_val, n_glob_val, c_glob_val;
    logic [bkmp_pkg::POS_W-1:0]            r_glob_pos, n_glob_pos, c_glob_pos;
    logic                                  found, dropped;
    logic [bkmp_pkg::POS_W-1:0]            key_pos;
    logic signed [bkmp_pkg::VAL_W-1:0]     key_val;
    logic                                  frame_done;
    logic signed [bkmp_pkg::VAL_W-1:0]     x;

    always_comb begin
        x           = i_in.sample;
        c_phase     = i_in.clear ? PH_SEARCH : r_phase;
        c_pos       = i_in.clear ? '0 : r_next_position;
        c_prev      = i_in.clear ? '0 : r_prev;
        c_bell_val  = i_in.clear ? '0 : r_bell_val;
        c_bell_pos  = i_in.clear ? '0 : r_bell_pos;
        c_key_count = i_in.clear ? '0 : r_key_count;
        c_glob_val  = i_in.clear ? '0 : r_glob_val;
        c_glob_pos  = i_in.clear ? '0 : r_glob_pos;

        frame_done = ({1'b0, c_pos} + (bkmp_pkg::POS_W + 1)'(1))
                     >= {1'b0, i_frame_length};

        n_phase     = c_phase;
        n_bell_val  = c_bell_val;
        n_bell_pos  = c_bell_pos;
        n_key_count = c_key_count;
        n_glob_val  = c_glob_val;
        n_glob_pos  = c_glob_pos;
        found       = 1'b0;
        dropped     = 1'b0;
        key_pos     = '0;
        key_val     = '0;

        case (c_phase)
            PH_SEARCH: begin
                if (c_prev < 0 && x >= 0) begin
                    n_bell_val = x;
                    n_bell_pos = c_pos;
                    n_phase    = PH_BELL;
                end else if (frame_done) begin
                    n_phase = PH_END;
                end
            end
            PH_BELL: begin
                if (c_prev >= 0 && x < 0) begin
                    key_pos = c_bell_pos;
                    key_val = c_bell_val;
                    if (c_key_count < bkmp_pkg::KEY_CNT_W'(bkmp_pkg::KEY_MAX)) begin
                        found       = 1'b1;
                        n_key_count = c_key_count + bkmp_pkg::KEY_CNT_W'(1);
                        if (c_glob_val < c_bell_val) begin
                            n_glob_val = c_bell_val;
                            n_glob_pos = c_bell_pos;
                        end
                    end else begin
                        dropped = 1'b1;
                    end
                    n_phase = PH_SEARCH;
                end else if (c_bell_val < x) begin
                    n_bell_val = x;
                    n_bell_pos = c_pos;
                end
            end
            default: begin
                n_phase = PH_END;
            end
        endcase

        n_next_position = c_pos + bkmp_pkg::POS_W'(1);

        o_result.phase           = n_phase;
        o_result.sample_position = c_pos;
        o_result.key_found       = found;
        o_result.key_dropped     = dropped;
        o_result.key_position    = key_pos;
        o_result.key_value       = key_val;
        o_result.key_total       = n_key_count;
        o_result.best_position   = n_glob_pos;
        o_result.best_value      = n_glob_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SEARCH;
            r_next_position <= '0;
            r_prev          <= '0;
            r_bell_val      <= '0;
            r_bell_pos      <= '0;
            r_key_count     <= '0;
            r_glob_val      <= '0;
            r_glob_pos      <= '0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_next_position <= n_next_position;
            r_prev          <= x;
            r_bell_val      <= n_bell_val;
            r_bell_pos      <= n_bell_pos;
            r_key_count     <= n_key_count;
            r_glob_val      <= n_glob_val;
            r_glob_pos      <= n_glob_pos;
        end
    end

    `BKMP_ASSERT_NOW(a_key_count_bound, i_clk, i_rst_n,
        r_key_count <= bkmp_pkg::KEY_CNT_W'(bkmp_pkg::KEY_MAX))
    `BKMP_ASSERT_NOW(a_found_xor_dropped, i_clk, i_rst_n, !(found && dropped))
    `BKMP_ASSERT_NEXT(a_key_closes_bell, i_clk, i_rst_n,
        i_accept && (found || dropped), r_phase == PH_SEARCH)
    `BKMP_ASSERT_NEXT(a_clear_restarts, i_clk, i_rst_n,
        i_accept && i_in.clear, r_next_position == bkmp_pkg::POS_W'(1))

endmodule

// ===== rtl/bell_key_maximum_picker.sv =====
// Key maximum picker: takes one correlation sample per clock and reports, for
// each sample, the bell phase, any key maximum closed by it and the best key so
// far. One transaction in and one out per clock while neither side stalls; a
// result is registered in the output register, or while the output is stalled
// in the one-entry skid stage behind it; input stall rises only when the skid
// stage holds a transaction. frame_length is written through the configuration
// channel, which is always ready; write it only while the block is idle.
// depends on bkmp_pkg and bkmp_core
module bell_key_maximum_picker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  bkmp_pkg::t_in                         i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output bkmp_pkg::t_out                        o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bkmp_pkg::FRAME_LEN_W-1:0]      i_cfg_data
);

    logic [bkmp_pkg::FRAME_LEN_W-1:0] r_frame_length;
    logic                             r_out_valid;
    bkmp_pkg::t_out                   r_out_data;
    logic                             r_skid_valid;
    bkmp_pkg::t_out                   r_skid_data;
    bkmp_pkg::t_out                   result;
    logic                             accept;
    logic                             out_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    bkmp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in           (i_in_data),
        .i_frame_length (r_frame_length),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= bkmp_pkg::FRAME_LEN_RESET;
        end else if (i_cfg_valid) begin
            r_frame_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end else if (accept) begin
            r_skid_data <= result;
        end
    end

endmodule
